>>> hw/rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int SPQ_DEPTH    = 16;
   localparam int SPQ_TAG_BITS = 32;
   localparam int PRIO_W       = 8;
   localparam int IO_TAG_W     = 32;
   localparam int OCC_W        = 5;

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic shift_out;
   } cell_ctl_type;

endpackage : spq_pkg
`default_nettype wire

>>> hw/rtl/spq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Request and response channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [PRIO_W-1:0]   entry_priority;
   logic [IO_TAG_W-1:0] entry_tag;

   modport source (output valid, req_type, entry_priority, entry_tag, input ready);
   modport sink   (input valid, req_type, entry_priority, entry_tag, output ready);
endinterface : spq_req_if

interface spq_rsp_if import spq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                out_valid;
   logic [PRIO_W-1:0]   out_priority;
   logic [IO_TAG_W-1:0] out_tag;
   logic [1:0]          status;
   logic                is_empty;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, out_valid, out_priority, out_tag, status, is_empty,
                   occupancy, input ready);
   modport sink   (input valid, out_valid, out_priority, out_tag, status, is_empty,
                   occupancy, output ready);
endinterface : spq_rsp_if
`default_nettype wire

>>> hw/rtl/stable_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Sorted-list priority queue with arrival order among equal priorities.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while responses are drained; its
// response sits in the output register from the following cycle, and the next
// request is taken in the same cycle that response transfers, so a stalled
// response holds off the input. Entries live in a row of QueueDepth cells that
// all compare against the incoming priority in parallel and shift one place
// together, whatever the occupancy. The head is always cell 0.
module stable_priority_queue_unit import spq_pkg::*; #(
   parameter int QueueDepth = SPQ_DEPTH,
   parameter int TagBits    = SPQ_TAG_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int CountW = $clog2(QueueDepth + 1);

   logic [CountW-1:0]   count_ff, count_in;
   logic                rsp_valid_ff;
   logic                out_valid_ff, out_valid_in;
   logic [PRIO_W-1:0]   out_prio_ff, out_prio_in;
   logic [IO_TAG_W-1:0] out_tag_ff, out_tag_in;
   status_type          status_ff, status_in;

   logic                req_xfer;
   logic                is_full, is_empty;
   logic [TagBits-1:0]  new_tag;
   cell_ctl_type        ctl;

   logic [QueueDepth-1:0] keep;
   logic [PRIO_W-1:0]     prio  [QueueDepth];
   logic [TagBits-1:0]    tag   [QueueDepth];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign is_full        = (count_ff == CountW'(QueueDepth));
   assign is_empty       = (count_ff == '0);
   assign new_tag        = TagBits'(req_chan.entry_tag);

   assign ctl.insert    = req_xfer && (req_chan.req_type == REQ_ENQUEUE) && !is_full;
   assign ctl.shift_out = req_xfer && (req_chan.req_type == REQ_DEQUEUE) && !is_empty;

   for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
      logic               left_keep;
      logic [PRIO_W-1:0]  left_prio, right_prio;
      logic [TagBits-1:0] left_tag, right_tag;

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_prio = req_chan.entry_priority;
         assign left_tag  = new_tag;
      end else begin : g_body
         assign left_keep = keep[i-1];
         assign left_prio = prio[i-1];
         assign left_tag  = tag[i-1];
      end

      if (i == QueueDepth - 1) begin : g_tail
         assign right_prio = prio[i];
         assign right_tag  = tag[i];
      end else begin : g_mid
         assign right_prio = prio[i+1];
         assign right_tag  = tag[i+1];
      end

      spq_cell #(
         .TagBits (TagBits)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (CountW'(i) < count_ff),
         .new_prio   (req_chan.entry_priority),
         .new_tag    (new_tag),
         .left_keep  (left_keep),
         .left_prio  (left_prio),
         .left_tag   (left_tag),
         .right_prio (right_prio),
         .right_tag  (right_tag),
         .keep       (keep[i]),
         .prio       (prio[i]),
         .tag        (tag[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      out_valid_in = 1'b0;
      out_prio_in  = '0;
      out_tag_in   = '0;
      status_in    = STATUS_DONE;
      unique case (req_chan.req_type)
         REQ_ENQUEUE: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CountW'(1);
            end
         end
         REQ_DEQUEUE: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in     = count_ff - CountW'(1);
               out_valid_in = 1'b1;
               out_prio_in  = prio[0];
               out_tag_in   = IO_TAG_W'(tag[0]);
            end
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         out_valid_ff <= out_valid_in;
         out_prio_ff  <= out_prio_in;
         out_tag_ff   <= out_tag_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_valid    = out_valid_ff;
   assign rsp_chan.out_priority = out_prio_ff;
   assign rsp_chan.out_tag      = out_tag_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.is_empty     = (count_ff == '0);
   assign rsp_chan.occupancy    = OCC_W'(count_ff);

endmodule : stable_priority_queue_unit
`default_nettype wire

>>> hw/rtl/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
   parameter int TagBits = SPQ_TAG_BITS
) (
   input  wire logic               clock,
   input  wire cell_ctl_type       ctl,
   input  wire logic               occupied,
   input  wire logic [PRIO_W-1:0]  new_prio,
   input  wire logic [TagBits-1:0] new_tag,
   input  wire logic               left_keep,
   input  wire logic [PRIO_W-1:0]  left_prio,
   input  wire logic [TagBits-1:0] left_tag,
   input  wire logic [PRIO_W-1:0]  right_prio,
   input  wire logic [TagBits-1:0] right_tag,
   output logic                    keep,
   output logic [PRIO_W-1:0]       prio,
   output logic [TagBits-1:0]      tag
);

   logic [PRIO_W-1:0]  prio_ff, prio_in;
   logic [TagBits-1:0] tag_ff, tag_in;

   // entry stays put on insert when it sorts at or before the new one
   assign keep = occupied && (prio_ff <= new_prio);
   assign prio = prio_ff;
   assign tag  = tag_ff;

   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      if (ctl.insert) begin
         if (keep) begin
            prio_in = prio_ff;
            tag_in  = tag_ff;
         end else if (left_keep) begin
            prio_in = new_prio;
            tag_in  = new_tag;
         end else begin
            prio_in = left_prio;
            tag_in  = left_tag;
         end
      end else if (ctl.shift_out) begin
         prio_in = right_prio;
         tag_in  = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

endmodule : spq_cell
`default_nettype wire
